// ===== sv/expression_language_tokenizer_assert.svh =====
// ----------------------------------------------------------------------------
// expression_language_tokenizer assertion macros
// Clocked property checks used by the tokenizer RTL, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_LANGUAGE_TOKENIZER_ASSERT_SVH
`define EXPRESSION_LANGUAGE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ELT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression is never true outside reset
`define ELT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ELT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ELT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== sv/elt_pkg.sv =====
// ----------------------------------------------------------------------------
// elt_pkg
// Types, codes, constants and character-class helpers of the tokenizer.
// ----------------------------------------------------------------------------
package elt_pkg;

	localparam int NAME_CHARS_DEF = 8;
	localparam int INDEX_BITS_DEF = 16;

	localparam logic [30:0] NUMBER_MAX = 31'h7FFF_FFFF;

	// keywords packed first byte lowest
	localparam logic [63:0] WORD_PRINT = 64'h0000_0074_6E69_7270;
	localparam logic [63:0] WORD_WHILE = 64'h0000_0065_6C69_6877;
	localparam logic [63:0] WORD_IF    = 64'h0000_0000_0000_6669;

	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [4:0] {
		TK_NUM    = 5'd0,
		TK_IDENT  = 5'd1,
		TK_PLUS   = 5'd2,
		TK_MINUS  = 5'd3,
		TK_STAR   = 5'd4,
		TK_SLASH  = 5'd5,
		TK_EQ     = 5'd6,
		TK_EQEQ   = 5'd7,
		TK_GT     = 5'd8,
		TK_LT     = 5'd9,
		TK_PRINT  = 5'd10,
		TK_WHILE  = 5'd11,
		TK_IF     = 5'd12,
		TK_LBRACE = 5'd13,
		TK_RBRACE = 5'd14,
		TK_LPAREN = 5'd15,
		TK_RPAREN = 5'd16,
		TK_EOF    = 5'd17,
		TK_ERROR  = 5'd18
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_UNEXPECTED = 2'd1,
		ERR_TOO_LONG   = 2'd2
	} err_code_t;

	typedef enum logic [4:0] {
		MODE_IDLE = 5'b00001,
		MODE_WORD = 5'b00010,
		MODE_NUM  = 5'b00100,
		MODE_EQ   = 5'b01000,
		MODE_ERR  = 5'b10000
	} scan_mode_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [30:0] num;
		logic [63:0] name;
		logic [3:0]  nlen;
		err_code_t   err;
		logic [7:0]  off;
		logic [15:0] idx;
	} token_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic token_t plain_token(input tok_kind_t kind);
		token_t t;
		t      = '0;
		t.kind = kind;
		return t;
	endfunction

	// keyword or identifier at the end of a letter-digit run
	function automatic token_t word_token(input logic [63:0] buf_v, input logic [3:0] len);
		token_t t;
		t = '0;
		if (len == 4'd5 && buf_v == WORD_PRINT) begin
			t.kind = TK_PRINT;
		end else if (len == 4'd5 && buf_v == WORD_WHILE) begin
			t.kind = TK_WHILE;
		end else if (len == 4'd2 && buf_v == WORD_IF) begin
			t.kind = TK_IF;
		end else begin
			t.kind = TK_IDENT;
			t.name = buf_v;
			t.nlen = len;
		end
		return t;
	endfunction

	// single-byte operators and brackets, error for anything else
	function automatic tok_kind_t symbol_kind(input logic [7:0] c);
		tok_kind_t k;
		unique case (c)
			CH_PLUS:   k = TK_PLUS;
			CH_MINUS:  k = TK_MINUS;
			CH_STAR:   k = TK_STAR;
			CH_SLASH:  k = TK_SLASH;
			CH_GT:     k = TK_GT;
			CH_LT:     k = TK_LT;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			CH_LBRACE: k = TK_LBRACE;
			CH_RBRACE: k = TK_RBRACE;
			default:   k = TK_ERROR;
		endcase
		return k;
	endfunction

endpackage

// ===== sv/expression_language_tokenizer.sv =====
// ----------------------------------------------------------------------------
// expression_language_tokenizer
// Byte-stream lexer for a small expression language, one token per beat out.
// ----------------------------------------------------------------------------
// Source bytes enter one per beat with is_last on the final byte of a text;
// tokens leave one per beat with a running index and last_of_run set on the
// final token a byte produced. A byte is registered, then one pass of logic
// against the scanner state builds all of its tokens (zero to three) into a
// small result queue. A byte that yields at most one token moves through
// without holding the input unless the output stalls; a byte yielding more
// holds the input while the result queue drains, one token per output beat.
// After the end-of-file token the scanner and token count return to their
// reset values.
`include "expression_language_tokenizer_assert.svh"

module expression_language_tokenizer #(
	parameter int NAME_CHARS = elt_pkg::NAME_CHARS_DEF,
	parameter int INDEX_BITS = elt_pkg::INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  input_char,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [30:0] number_value,
	output logic [63:0] name_chars,
	output logic [3:0]  name_length,
	output logic [1:0]  error_code,
	output logic [7:0]  offending_char,
	output logic [15:0] token_index,
	output logic        last_of_run
);
	import elt_pkg::*;

	localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;

	token_t                tok_s2 [3];
	logic [1:0]            rem_s2;

	scan_mode_t            mode_q;
	logic [63:0]           wbuf_q;
	logic [3:0]            wlen_q;
	logic [30:0]           acc_q;
	logic [INDEX_BITS-1:0] cnt_q;

	scan_mode_t            mode_d;
	logic [63:0]           wbuf_d;
	logic [3:0]            wlen_d;
	logic [30:0]           acc_d;
	logic [INDEX_BITS-1:0] cnt_d;
	logic [INDEX_BITS-1:0] cnt_run;

	token_t                cand [4];
	logic [3:0]            cand_v;
	token_t                tok_d [3];
	logic [1:0]            n_d;
	logic                  handled;
	tok_kind_t             sym;

	logic [34:0]           acc_sum;
	logic [30:0]           acc_inc;

	logic                  in_fire;
	logic                  out_fire;
	logic                  s2_free;
	logic                  adv;

	assign out_valid = rem_s2 != 2'd0;
	assign out_fire  = out_valid & ~out_stall;
	assign s2_free   = (rem_s2 == 2'd0) | ((rem_s2 == 2'd1) & out_fire);
	assign adv       = valid_s1 & s2_free;
	assign in_stall  = valid_s1 & ~s2_free;
	assign in_fire   = in_valid & ~in_stall;

	// saturating acc * 10 + digit
	assign acc_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, char_s1[3:0]};
	assign acc_inc = (acc_sum > {4'd0, NUMBER_MAX}) ? NUMBER_MAX : acc_sum[30:0];

	assign sym = symbol_kind(char_s1);

	always_comb begin
		mode_d  = mode_q;
		wbuf_d  = wbuf_q;
		wlen_d  = wlen_q;
		acc_d   = acc_q;
		handled = 1'b0;
		cand_v  = '0;
		for (int i = 0; i < 4; i++) begin
			cand[i] = '0;
		end

		// finish or extend the pending token
		unique case (mode_q)
			MODE_WORD: begin
				if (is_alpha(char_s1) || is_digit(char_s1)) begin
					handled = 1'b1;
					if (32'(wlen_q) >= NAME_CHARS) begin
						cand[0]     = plain_token(TK_ERROR);
						cand[0].err = ERR_TOO_LONG;
						cand_v[0]   = 1'b1;
						wbuf_d      = '0;
						wlen_d      = '0;
						mode_d      = MODE_ERR;
					end else begin
						wbuf_d[8*wlen_q[2:0] +: 8] = char_s1;
						wlen_d                     = wlen_q + 4'd1;
					end
				end else begin
					cand[0]   = word_token(wbuf_q, wlen_q);
					cand_v[0] = 1'b1;
					wbuf_d    = '0;
					wlen_d    = '0;
					mode_d    = MODE_IDLE;
				end
			end
			MODE_NUM: begin
				if (is_digit(char_s1)) begin
					handled = 1'b1;
					acc_d   = acc_inc;
				end else begin
					cand[0]     = plain_token(TK_NUM);
					cand[0].num = acc_q;
					cand_v[0]   = 1'b1;
					acc_d       = '0;
					mode_d      = MODE_IDLE;
				end
			end
			MODE_EQ: begin
				mode_d    = MODE_IDLE;
				cand_v[0] = 1'b1;
				if (char_s1 == CH_EQUALS) begin
					handled = 1'b1;
					cand[0] = plain_token(TK_EQEQ);
				end else begin
					cand[0] = plain_token(TK_EQ);
				end
			end
			MODE_ERR: begin
				handled = 1'b1;
			end
			MODE_IDLE: begin
				mode_d = MODE_IDLE;
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		// byte that starts something new
		if (!handled) begin
			if (is_alpha(char_s1)) begin
				mode_d = MODE_WORD;
				wbuf_d = {56'd0, char_s1};
				wlen_d = 4'd1;
			end else if (is_digit(char_s1)) begin
				mode_d = MODE_NUM;
				acc_d  = {27'd0, char_s1[3:0]};
			end else if (is_space(char_s1)) begin
				mode_d = mode_d;
			end else if (char_s1 == CH_EQUALS) begin
				mode_d = MODE_EQ;
			end else begin
				cand[1]   = plain_token(sym);
				cand_v[1] = 1'b1;
				if (sym == TK_ERROR) begin
					cand[1].err = ERR_UNEXPECTED;
					cand[1].off = char_s1;
					mode_d      = MODE_ERR;
				end
			end
		end

		// end of text: flush, eof, back to reset state
		if (last_s1) begin
			unique case (mode_d)
				MODE_WORD: begin
					cand[2]   = word_token(wbuf_d, wlen_d);
					cand_v[2] = 1'b1;
				end
				MODE_NUM: begin
					cand[2]     = plain_token(TK_NUM);
					cand[2].num = acc_d;
					cand_v[2]   = 1'b1;
				end
				MODE_EQ: begin
					cand[2]   = plain_token(TK_EQ);
					cand_v[2] = 1'b1;
				end
				default: begin
					cand_v[2] = 1'b0;
				end
			endcase
			cand[3]   = plain_token(TK_EOF);
			cand_v[3] = 1'b1;
			mode_d    = MODE_IDLE;
			wbuf_d    = '0;
			wlen_d    = '0;
			acc_d     = '0;
		end

		// pack tokens in order and number them
		n_d     = '0;
		cnt_run = cnt_q;
		for (int i = 0; i < 3; i++) begin
			tok_d[i] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				tok_d[n_d]     = cand[i];
				tok_d[n_d].idx = 16'(cnt_run);
				n_d            = n_d + 2'd1;
				if (cand[i].kind != TK_EOF && cnt_run != INDEX_MAX) begin
					cnt_run = cnt_run + 1'b1;
				end
			end
		end
		cnt_d = last_s1 ? '0 : cnt_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire | (valid_s1 & ~adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= input_char;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= '0;
			mode_q <= MODE_IDLE;
			wbuf_q <= '0;
			wlen_q <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (adv) begin
			rem_s2 <= n_d;
			mode_q <= mode_d;
			wbuf_q <= wbuf_d;
			wlen_q <= wlen_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
		end else if (out_fire) begin
			rem_s2 <= rem_s2 - 2'd1;
		end
	end

	// result queue, head always in slot zero
	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2 <= tok_d;
		end else if (out_fire) begin
			tok_s2[0] <= tok_s2[1];
			tok_s2[1] <= tok_s2[2];
		end
	end

	assign token_kind     = tok_s2[0].kind;
	assign number_value   = tok_s2[0].num;
	assign name_chars     = tok_s2[0].name;
	assign name_length    = tok_s2[0].nlen;
	assign error_code     = tok_s2[0].err;
	assign offending_char = tok_s2[0].off;
	assign token_index    = tok_s2[0].idx;
	assign last_of_run    = rem_s2 == 2'd1;

	`ELT_ASSERT(a_eof_ends_run, clk, arst_n, (out_valid && token_kind == TK_EOF) |-> last_of_run, "eof is not the last token of its beat")
	`ELT_ASSERT(a_text_end_resets, clk, arst_n, (adv && last_s1) |=> (cnt_q == '0 && mode_q == MODE_IDLE && wlen_q == 4'd0), "scanner not reset after end of text")
	`ELT_NEVER(a_err_mode_silent, clk, arst_n, adv && mode_q == MODE_ERR && n_d != {1'b0, last_s1}, "error mode produced a token other than eof")
	`ELT_NEVER(a_word_len_bound, clk, arst_n, 32'(wlen_q) > NAME_CHARS, "word length beyond name limit")
	`ELT_NEVER(a_stall_needs_byte, clk, arst_n, in_stall && !valid_s1, "input stalled with no byte held")

endmodule

// ===== sim/token_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches both channels of the tokenizer, predicts the tokens of every
// accepted source byte and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module token_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  input_char,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  token_kind,
	input  logic [30:0] number_value,
	input  logic [63:0] name_chars,
	input  logic [3:0]  name_length,
	input  logic [1:0]  error_code,
	input  logic [7:0]  offending_char,
	input  logic [15:0] token_index,
	input  logic        last_of_run,
	output int          mismatches,
	output int          tokens_pending
);
	import elt_pkg::*;

	localparam int NAME_LIMIT = NAME_CHARS_DEF;
	localparam logic [15:0] INDEX_CAP = 16'((64'd1 << INDEX_BITS_DEF) - 64'd1);

	typedef struct packed {
		tok_kind_t   kind;
		logic [30:0] num;
		logic [63:0] name;
		logic [3:0]  nlen;
		err_code_t   err;
		logic [7:0]  off;
		logic [15:0] idx;
		logic        last;
	} token_beat_t;

	scan_mode_t  scan = MODE_IDLE;
	logic [63:0] word_buf = '0;
	logic [3:0]  word_len = '0;
	logic [30:0] number_acc = '0;
	logic [15:0] index_run = '0;

	token_beat_t step_tokens[$];
	token_beat_t expected_tokens[$];

	function automatic bit char_is_letter(input logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic bit char_is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic bit char_is_blank(input logic [7:0] c);
		return c inside {CH_SPACE, [8'h09:8'h0D]};
	endfunction

	function automatic tok_kind_t punct_kind(input logic [7:0] c);
		case (c)
			CH_PLUS:   return TK_PLUS;
			CH_MINUS:  return TK_MINUS;
			CH_STAR:   return TK_STAR;
			CH_SLASH:  return TK_SLASH;
			CH_GT:     return TK_GT;
			CH_LT:     return TK_LT;
			CH_LPAREN: return TK_LPAREN;
			CH_RPAREN: return TK_RPAREN;
			CH_LBRACE: return TK_LBRACE;
			CH_RBRACE: return TK_RBRACE;
			default:   return TK_ERROR;
		endcase
	endfunction

	task automatic queue_token(input tok_kind_t kind, input logic [30:0] num,
			input logic [63:0] name, input logic [3:0] nlen, input err_code_t err,
			input logic [7:0] off);
		token_beat_t t;
		if (step_tokens.size() >= 3)
			return;
		t.kind = kind;
		t.num  = num;
		t.name = name;
		t.nlen = nlen;
		t.err  = err;
		t.off  = off;
		t.idx  = index_run;
		t.last = 1'b0;
		step_tokens.push_back(t);
		if (kind != TK_EOF && index_run != INDEX_CAP)
			index_run++;
	endtask

	task automatic queue_plain(input tok_kind_t kind);
		queue_token(kind, '0, '0, '0, ERR_NONE, '0);
	endtask

	task automatic close_word();
		if (word_len == 4'd5 && word_buf == WORD_PRINT) begin
			queue_plain(TK_PRINT);
		end else if (word_len == 4'd5 && word_buf == WORD_WHILE) begin
			queue_plain(TK_WHILE);
		end else if (word_len == 4'd2 && word_buf == WORD_IF) begin
			queue_plain(TK_IF);
		end else begin
			queue_token(TK_IDENT, '0, word_buf, word_len, ERR_NONE, '0);
		end
		word_buf = '0;
		word_len = '0;
	endtask

	task automatic add_word_byte(input logic [7:0] c);
		if (word_len >= NAME_LIMIT) begin
			queue_token(TK_ERROR, '0, '0, '0, ERR_TOO_LONG, '0);
			word_buf = '0;
			word_len = '0;
			scan = MODE_ERR;
		end else begin
			word_buf[8 * word_len +: 8] = c;
			word_len++;
		end
	endtask

	task automatic add_decimal(input logic [7:0] c);
		logic [35:0] wide;
		wide = 36'(number_acc) * 36'd10 + 36'(c - 8'h30);
		number_acc = (wide > 36'(NUMBER_MAX)) ? NUMBER_MAX : wide[30:0];
	endtask

	task automatic open_lexeme(input logic [7:0] c);
		tok_kind_t k;
		if (char_is_letter(c)) begin
			scan = MODE_WORD;
			word_buf = '0;
			word_len = '0;
			add_word_byte(c);
		end else if (char_is_digit(c)) begin
			scan = MODE_NUM;
			number_acc = '0;
			add_decimal(c);
		end else if (char_is_blank(c)) begin
		end else if (c == CH_EQUALS) begin
			scan = MODE_EQ;
		end else begin
			k = punct_kind(c);
			if (k == TK_ERROR) begin
				queue_token(TK_ERROR, '0, '0, '0, ERR_UNEXPECTED, c);
				scan = MODE_ERR;
			end else begin
				queue_plain(k);
			end
		end
	endtask

	task automatic lex_byte(input logic [7:0] c, input logic last);
		bit consumed;
		token_beat_t t;
		consumed = 1'b0;
		step_tokens.delete();
		case (scan)
			MODE_WORD: begin
				if (char_is_letter(c) || char_is_digit(c)) begin
					add_word_byte(c);
					consumed = 1'b1;
				end else begin
					close_word();
					scan = MODE_IDLE;
				end
			end
			MODE_NUM: begin
				if (char_is_digit(c)) begin
					add_decimal(c);
					consumed = 1'b1;
				end else begin
					queue_token(TK_NUM, number_acc, '0, '0, ERR_NONE, '0);
					number_acc = '0;
					scan = MODE_IDLE;
				end
			end
			MODE_EQ: begin
				scan = MODE_IDLE;
				if (c == CH_EQUALS) begin
					queue_plain(TK_EQEQ);
					consumed = 1'b1;
				end else begin
					queue_plain(TK_EQ);
				end
			end
			MODE_ERR: consumed = 1'b1;
			default: scan = MODE_IDLE;
		endcase
		if (!consumed)
			open_lexeme(c);
		if (last) begin
			case (scan)
				MODE_WORD: close_word();
				MODE_NUM:  queue_token(TK_NUM, number_acc, '0, '0, ERR_NONE, '0);
				MODE_EQ:   queue_plain(TK_EQ);
				default:   ;
			endcase
			queue_plain(TK_EOF);
			scan = MODE_IDLE;
			word_buf = '0;
			word_len = '0;
			number_acc = '0;
			index_run = '0;
		end
		for (int i = 0; i < step_tokens.size(); i++) begin
			t = step_tokens[i];
			t.last = (i == step_tokens.size() - 1);
			expected_tokens.push_back(t);
		end
	endtask

	always @(posedge clk) begin
		token_beat_t got;
		token_beat_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				lex_byte(input_char, is_last);
			if (out_valid && !out_stall) begin
				got.kind = tok_kind_t'(token_kind);
				got.num  = number_value;
				got.name = name_chars;
				got.nlen = name_length;
				got.err  = err_code_t'(error_code);
				got.off  = offending_char;
				got.idx  = token_index;
				got.last = last_of_run;
				if (expected_tokens.size() == 0) begin
					mismatches++;
					$display("%0t: token beat with none expected: kind %0d idx %0d",
						$time, token_kind, token_index);
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want) begin
						mismatches++;
						$display("%0t: expected kind %0d num %0d name %h len %0d",
							$time, want.kind, want.num, want.name, want.nlen);
						$display("%0t: expected err %0d off %h idx %0d last %0d",
							$time, want.err, want.off, want.idx, want.last);
						$display("%0t: got      kind %0d num %0d name %h len %0d",
							$time, got.kind, got.num, got.name, got.nlen);
						$display("%0t: got      err %0d off %h idx %0d last %0d",
							$time, got.err, got.off, got.idx, got.last);
					end
				end
			end
			tokens_pending = expected_tokens.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds source texts to the tokenizer with random gaps and output stalls:
// a few hand-written texts, then random programs with noise.
// Token checking is done by token_stream_checker.
// ----------------------------------------------------------------------------
module testbench;
	import elt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  input_char;
	logic        is_last;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  token_kind;
	logic [30:0] number_value;
	logic [63:0] name_chars;
	logic [3:0]  name_length;
	logic [1:0]  error_code;
	logic [7:0]  offending_char;
	logic [15:0] token_index;
	logic        last_of_run;
	int          mismatches;
	int          tokens_pending;

	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	int          holds_requested = 0;
	logic [7:0]  text_q[$];

	expression_language_tokenizer dut (.*);

	token_stream_checker token_check (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#2_000_000;
		$display("[expression_language_tokenizer] ERROR");
		$finish;
	end

	function automatic logic [7:0] random_letter();
		return $urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 25))
			: 8'(8'h41 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] random_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	task automatic add_string(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		input_char <= c;
		is_last <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic send_string(input string s);
		text_q.delete();
		add_string(s);
		send_text();
	endtask

	// stop offering beats until every predicted token has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (tokens_pending == 0);
		@(negedge clk);
	endtask

	// well-formed lexemes with random content, some noise bytes
	task automatic build_program(input int min_lex);
		int n_lex;
		int pick;
		int len;
		string ops = "+-*/<>(){}=";
		string keywords[3] = '{"print", "while", "if"};
		logic [7:0] blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		text_q.delete();
		n_lex = $urandom_range(min_lex, min_lex + 9);
		repeat (n_lex) begin
			pick = $urandom_range(0, 19);
			if (pick < 5) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
				text_q.push_back(random_letter());
				repeat (len - 1)
					text_q.push_back($urandom_range(0, 2) == 0 ? random_digit() : random_letter());
			end else if (pick < 8) begin
				case ($urandom_range(0, 7))
					0: add_string("2147483647");
					1: add_string("2147483648");
					2: repeat ($urandom_range(10, 12)) text_q.push_back(random_digit());
					default: repeat ($urandom_range(1, 4)) text_q.push_back(random_digit());
				endcase
			end else if (pick < 10) begin
				add_string(keywords[$urandom_range(0, 2)]);
				if ($urandom_range(0, 3) == 0)
					text_q.push_back(random_digit());
			end else if (pick < 15) begin
				if ($urandom_range(0, 5) == 0)
					add_string("==");
				else
					text_q.push_back(ops[$urandom_range(0, ops.len() - 1)]);
			end else if (pick < 19) begin
				repeat ($urandom_range(1, 3)) text_q.push_back(blanks[$urandom_range(0, 5)]);
			end else begin
				text_q.push_back(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 1) == 0)
				text_q.push_back(CH_SPACE);
		end
		if ($urandom_range(0, 5) == 0)
			text_q.insert($urandom_range(0, text_q.size() - 1), 8'($urandom_range(0, 255)));
	endtask

	// output side: random stall per beat, long hold on request
	initial begin : receiver
		int hold;
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (holds_done != holds_requested) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (150) @(negedge clk);
			end
			hold = rx_quiet ? 0 : $urandom_range(0, 11);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int text_count;
		int random_bytes;
		text_count = 0;
		random_bytes = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		input_char = '0;
		is_last = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_string("print{if(a)}");
		send_string("while=");
		send_string("+-*/><==");
		send_string("$a");
		text_q = {8'h00};
		send_text();
		text_q = {8'hFF};
		send_text();
		drain();

		while (random_bytes < 230) begin
			text_count++;
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (text_count % 5 == 0)
				drain();
			if (text_count == 2 || text_count == 7) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b0;
				holds_requested++;
				build_program(10);
			end else begin
				build_program(1);
			end
			send_text();
			random_bytes += text_q.size();
		end
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("[expression_language_tokenizer] OK");
		end else begin
			$display("[expression_language_tokenizer] ERROR");
		end
		$finish;
	end

endmodule
